// ----- rtl/core/rtsm_pkg.sv -----
// Shared types, constants and codes of the throttle and steering mapper.
package rtsm_pkg;

	localparam int STICK_W   = 8;
	localparam int AGE_W     = 16;
	localparam int PULSE_W   = 12;
	localparam int HOLD_W    = 6;
	localparam int X_W       = STICK_W + 1;
	localparam int SPAN_W    = PULSE_W + 1;
	localparam int PROD_W    = X_W + SPAN_W;
	localparam int MAG_W     = 20;
	localparam int QUO_W     = MAG_W + 1;
	localparam int SUM_W     = QUO_W + 1;
	localparam int DEN_W     = STICK_W;

	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int IDX_LSB   = 2;
	localparam int IDX_W     = 3;

	localparam logic [STICK_W-1:0] STICK_CENTER = STICK_W'(127);
	localparam logic [STICK_W-1:0] STICK_MAX    = STICK_W'(255);
	localparam logic [PULSE_W-1:0] SERVO_CENTER = PULSE_W'(90);
	localparam logic [PULSE_W-1:0] PULSE_MAX    = PULSE_W'(4095);
	localparam logic [STICK_W-1:0] DEAD_BAND    = STICK_W'(13);
	localparam logic [PULSE_W-1:0] BRAKE_DROP   = PULSE_W'(10);
	localparam logic [HOLD_W-1:0]  HOLD_BRAKE   = HOLD_W'(45);
	localparam logic [HOLD_W-1:0]  HOLD_NEUTRAL = HOLD_W'(35);
	localparam logic [HOLD_W-1:0]  HOLD_NONE    = HOLD_W'(0);

	localparam logic OP_THROTTLE = 1'b0;
	localparam logic OP_STEER    = 1'b1;
	localparam logic TGT_ESC     = 1'b0;
	localparam logic TGT_SERVO   = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_CUTOFF_MS,
		REG_ESC_CENTER,
		REG_ESC_NEUTRAL,
		REG_ESC_FULL_FWD,
		REG_MIN_REVERSE,
		REG_MAX_REVERSE,
		REG_MIN_SERVO,
		REG_MAX_SERVO
	} reg_idx_t;

	typedef struct packed {
		logic [AGE_W-1:0]   cutoff_ms;
		logic [STICK_W-1:0] esc_center;
		logic [PULSE_W-1:0] esc_neutral;
		logic [PULSE_W-1:0] esc_full_fwd;
		logic [PULSE_W-1:0] min_reverse;
		logic [PULSE_W-1:0] max_reverse;
		logic [PULSE_W-1:0] min_servo;
		logic [PULSE_W-1:0] max_servo;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cutoff_ms:    AGE_W'(500),
		esc_center:   STICK_W'(127),
		esc_neutral:  PULSE_W'(1500),
		esc_full_fwd: PULSE_W'(2000),
		min_reverse:  PULSE_W'(1000),
		max_reverse:  PULSE_W'(1500),
		min_servo:    PULSE_W'(0),
		max_servo:    PULSE_W'(180)
	};

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] num_mag;
		logic [DEN_W-1:0] den_mag;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- rtl/core/rtsm_regs.sv -----
// APB configuration register file of the throttle and steering mapper.
module rtsm_regs
	import rtsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[IDX_LSB +: IDX_W]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_CUTOFF_MS:    cfg_q.cutoff_ms    <= pwdata[AGE_W-1:0];
				REG_ESC_CENTER:   cfg_q.esc_center   <= pwdata[STICK_W-1:0];
				REG_ESC_NEUTRAL:  cfg_q.esc_neutral  <= pwdata[PULSE_W-1:0];
				REG_ESC_FULL_FWD: cfg_q.esc_full_fwd <= pwdata[PULSE_W-1:0];
				REG_MIN_REVERSE:  cfg_q.min_reverse  <= pwdata[PULSE_W-1:0];
				REG_MAX_REVERSE:  cfg_q.max_reverse  <= pwdata[PULSE_W-1:0];
				REG_MIN_SERVO:    cfg_q.min_servo    <= pwdata[PULSE_W-1:0];
				REG_MAX_SERVO:    cfg_q.max_servo    <= pwdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CUTOFF_MS:    prdata = PDATA_W'(cfg_q.cutoff_ms);
			REG_ESC_CENTER:   prdata = PDATA_W'(cfg_q.esc_center);
			REG_ESC_NEUTRAL:  prdata = PDATA_W'(cfg_q.esc_neutral);
			REG_ESC_FULL_FWD: prdata = PDATA_W'(cfg_q.esc_full_fwd);
			REG_MIN_REVERSE:  prdata = PDATA_W'(cfg_q.min_reverse);
			REG_MAX_REVERSE:  prdata = PDATA_W'(cfg_q.max_reverse);
			REG_MIN_SERVO:    prdata = PDATA_W'(cfg_q.min_servo);
			REG_MAX_SERVO:    prdata = PDATA_W'(cfg_q.max_servo);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/rtsm_div.sv -----
// Iterative signed divider, two quotient bits per cycle, truncating toward zero.
module rtsm_div
	import rtsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEPS  = 2;
	localparam int CYCLES = MAG_W / STEPS;
	localparam int CNT_W  = $clog2(CYCLES);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [MAG_W-1:0] num_nx;
	logic [DEN_W-1:0] rem_nx;
	logic [DEN_W:0]   trial;

	always_comb begin
		num_nx = num_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < STEPS; i++) begin
			trial  = {rem_nx, num_nx[MAG_W-1]};
			num_nx = {num_nx[MAG_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial     = trial - {1'b0, den_q};
				num_nx[0] = 1'b1;
			end
			rem_nx = trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CYCLES - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num_mag;
			den_q <= req.den_mag;
			neg_q <= req.neg;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

// ----- rtl/core/rc_throttle_steer_mapper.sv -----
// Top level of the throttle and steering mapper: command sequencer and result register.
//
// One stick command is taken at a time; in_ready is high only while the sequencer is idle.
// A command that needs a linear map passes through the multiplier and the shared divider
// (two quotient bits per cycle); S_WAIT then offsets and clamps the quotient and S_CHK
// compares it. The dead band, a centered steering stick and a stop sequence skip the
// divider. Each result is then held in the output register, and up to four results
// (brake, neutral, servo center, new pulse) come from one command. The mapped ESC pulse is
// sent only when it differs from the last mapped ESC pulse sent. Configuration must be written
// through the APB port only while no command is in flight; the block does not enforce it.
module rc_throttle_steer_mapper
	import rtsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [STICK_W-1:0] stick_value,
	input  logic [AGE_W-1:0]   link_age_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               target,
	output logic [PULSE_W-1:0] pulse_value,
	output logic [HOLD_W-1:0]  hold_ms,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_WAIT,
		S_CHK,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		ST_BRAKE,
		ST_NEUTRAL,
		ST_SERVO,
		ST_MAIN
	} step_t;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t                   state_q;
	step_t                    step_q;
	logic                     stopped_q;
	logic                     forward_q;
	logic [PULSE_W-1:0]       last_esc_q;
	logic                     op_q;
	logic                     do_stop_q;
	logic                     do_main_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [SPAN_W-1:0] span_q;
	logic [DEN_W-1:0]         den_q;
	logic                     den_neg_q;
	logic [PULSE_W-1:0]       c_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [PULSE_W-1:0]       result_q;
	logic                     out_valid_q;
	logic                     target_q;
	logic [PULSE_W-1:0]       pulse_q;
	logic [HOLD_W-1:0]        hold_q;
	logic                     last_q;

	logic                     timeout;
	logic                     stop_hit;
	logic                     fwd;
	logic                     rev;
	logic signed [X_W-1:0]    x_in;
	logic signed [SPAN_W-1:0] span_in;
	logic [DEN_W-1:0]         den_in;
	logic                     den_neg_in;
	logic [PULSE_W-1:0]       c_in;
	logic [PROD_W-1:0]        prod_abs;
	logic [SUM_W-1:0]         sum;
	logic [PULSE_W-1:0]       clamped;
	logic [PULSE_W-1:0]       brake_val;
	logic                     pulse_new;
	logic                     out_free;

	rtsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// decode the command at transfer
	always_comb begin
		timeout  = link_age_ms > cfg.cutoff_ms;
		stop_hit = timeout || (stick_value == cfg.esc_center);
		fwd      = stick_value > cfg.esc_center;
		rev      = ({1'b0, stick_value} + {1'b0, DEAD_BAND}) < {1'b0, cfg.esc_center};
		x_in       = $signed({1'b0, stick_value}) - $signed({1'b0, STICK_CENTER});
		span_in    = $signed({1'b0, cfg.max_servo}) - $signed({1'b0, SERVO_CENTER});
		den_in     = STICK_MAX - STICK_CENTER;
		den_neg_in = 1'b0;
		c_in       = SERVO_CENTER;
		if (opcode == OP_THROTTLE) begin
			if (fwd) begin
				x_in    = $signed({1'b0, stick_value}) - $signed({1'b0, cfg.esc_center});
				span_in = $signed({1'b0, cfg.esc_full_fwd}) - $signed({1'b0, cfg.esc_neutral});
				den_in  = STICK_MAX - cfg.esc_center;
				c_in    = cfg.esc_neutral;
			end else begin
				x_in    = $signed({1'b0, stick_value});
				span_in = $signed({1'b0, cfg.max_reverse}) - $signed({1'b0, cfg.min_reverse});
				den_in  = cfg.esc_center;
				c_in    = cfg.min_reverse;
			end
		end else if (stick_value > STICK_CENTER) begin
			span_in    = $signed({1'b0, cfg.min_servo}) - $signed({1'b0, SERVO_CENTER});
			den_in     = STICK_CENTER;
			den_neg_in = 1'b1;
		end
	end

	always_comb begin
		prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		div_req.start   = (state_q == S_DIV);
		div_req.neg     = prod_q[PROD_W-1] ^ den_neg_q;
		div_req.num_mag = prod_abs[MAG_W-1:0];
		div_req.den_mag = den_q;

		sum = {div_rsp.quo[QUO_W-1], div_rsp.quo} + SUM_W'(c_q);
		if (sum[SUM_W-1]) begin
			clamped = '0;
		end else if (sum[SUM_W-2:0] > (SUM_W-1)'(PULSE_MAX)) begin
			clamped = PULSE_MAX;
		end else begin
			clamped = sum[PULSE_W-1:0];
		end

		brake_val = (cfg.esc_neutral < BRAKE_DROP) ? '0 : cfg.esc_neutral - BRAKE_DROP;
		pulse_new = (op_q == OP_STEER) || (result_q != last_esc_q);
		out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_BRAKE;
			stopped_q   <= 1'b0;
			forward_q   <= 1'b1;
			last_esc_q  <= '0;
			out_valid_q <= 1'b0;
			op_q        <= OP_THROTTLE;
			do_stop_q   <= 1'b0;
			do_main_q   <= 1'b0;
		end else begin
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= opcode;
						do_stop_q <= 1'b0;
						do_main_q <= 1'b0;
						if (opcode == OP_THROTTLE) begin
							if (stop_hit) begin
								if (!stopped_q) begin
									stopped_q <= 1'b1;
									do_stop_q <= 1'b1;
									step_q    <= ST_BRAKE;
									state_q   <= S_EMIT;
								end
							end else if (fwd) begin
								stopped_q <= 1'b0;
								forward_q <= 1'b1;
								state_q   <= S_MUL;
							end else if (rev) begin
								stopped_q <= forward_q;
								do_stop_q <= forward_q;
								forward_q <= 1'b0;
								state_q   <= S_MUL;
							end else begin
								stopped_q <= 1'b0;
								forward_q <= 1'b1;
								state_q   <= S_CHK;
							end
						end else if (!timeout) begin
							if (stick_value == STICK_CENTER) begin
								state_q <= S_CHK;
							end else begin
								state_q <= S_MUL;
							end
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					do_main_q <= pulse_new;
					if ((op_q == OP_THROTTLE) && pulse_new) begin
						last_esc_q <= result_q;
					end
					if (do_stop_q) begin
						step_q  <= ST_BRAKE;
						state_q <= S_EMIT;
					end else if (pulse_new) begin
						step_q  <= ST_MAIN;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						case (step_q)
							ST_BRAKE: begin
								step_q <= ST_NEUTRAL;
							end
							ST_NEUTRAL: begin
								step_q <= ST_SERVO;
							end
							ST_SERVO: begin
								step_q <= ST_MAIN;
								if (!do_main_q) begin
									state_q <= S_IDLE;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			x_q       <= x_in;
			span_q    <= span_in;
			den_q     <= den_in;
			den_neg_q <= den_neg_in;
			c_q       <= c_in;
			result_q  <= (opcode == OP_THROTTLE) ? cfg.esc_neutral : SERVO_CENTER;
		end
		if (state_q == S_MUL) begin
			prod_q <= x_q * span_q;
		end
		if ((state_q == S_WAIT) && div_rsp.done) begin
			result_q <= clamped;
		end
		if ((state_q == S_EMIT) && out_free) begin
			case (step_q)
				ST_BRAKE: begin
					target_q <= TGT_ESC;
					pulse_q  <= brake_val;
					hold_q   <= HOLD_BRAKE;
					last_q   <= 1'b0;
				end
				ST_NEUTRAL: begin
					target_q <= TGT_ESC;
					pulse_q  <= cfg.esc_neutral;
					hold_q   <= HOLD_NEUTRAL;
					last_q   <= 1'b0;
				end
				ST_SERVO: begin
					target_q <= TGT_SERVO;
					pulse_q  <= SERVO_CENTER;
					hold_q   <= HOLD_NONE;
					last_q   <= !do_main_q;
				end
				default: begin
					target_q <= (op_q == OP_THROTTLE) ? TGT_ESC : TGT_SERVO;
					pulse_q  <= result_q;
					hold_q   <= HOLD_NONE;
					last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign target      = target_q;
	assign pulse_value = pulse_q;
	assign hold_ms     = hold_q;
	assign last        = last_q;

endmodule
